// ----- hdl/assert_macros.svh -----
// Assertion macros for the corner grid check
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/cgcc_pkg.sv -----
// Shared types, constants and helpers for the corner grid collinearity check
package cgcc_pkg;

  localparam int MAX_WIDTH  = 32;
  localparam int MAX_HEIGHT = 32;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);

  localparam int CFG_W      = 6;
  localparam int REG_IDX_W  = 1;
  localparam int AREA_W     = 2 * CFG_W;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_WIDTH  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_PATTERN_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0]     WIDTH_RESET        = 6'd9;
  localparam logic [CFG_W-1:0]     HEIGHT_RESET       = 6'd6;

  localparam int COORD_W    = 20;
  localparam int POINT_W    = 2 * COORD_W;
  localparam int OUT_W      = 8;
  localparam int COUNT_W    = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // arithmetic widths of the collinearity test
  localparam int MAG_W      = COORD_W;           // |difference|
  localparam int NORM_W     = 2 * MAG_W + 1;     // squared length, |dot|
  localparam int DOT_W      = NORM_W + 1;        // signed dot product
  localparam int COS_W      = 16;
  localparam logic [COS_W-1:0] COS_SQ_Q16 = 16'd64622;
  localparam int K_W        = NORM_W + COS_W;    // n1 * K
  localparam int LHS_W      = 2 * NORM_W;        // dot^2
  localparam int CMP_W      = LHS_W + COS_W;     // both sides of the compare
  localparam int OPA_W      = K_W;
  localparam int CHUNK_W    = 16;
  localparam int NCHUNK     = 4;
  localparam int OPB_W      = CHUNK_W * NCHUNK;
  localparam int CHUNK_IDX_W = $clog2(NCHUNK);
  localparam int PROD_W     = OPA_W + CHUNK_W;
  localparam int ACC_W      = CMP_W + 2;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } point_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD_ROW,
    S_LOAD_COL,
    S_MAC,
    S_CHECK,
    S_COMMIT
  } ctl_state_t;

  typedef enum logic [3:0] {
    OP_N1X,
    OP_N1Y,
    OP_N2X,
    OP_N2Y,
    OP_DOTX,
    OP_DOTY,
    OP_LHS,
    OP_K,
    OP_RHS
  } mac_op_t;

  typedef struct packed {
    logic                   take;
    logic                   load_row;
    logic                   load_col;
    logic                   mac_en;
    mac_op_t                op;
    logic [CHUNK_IDX_W-1:0] chunk;
    logic                   check;
    logic                   commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic row_test;
    logic col_test;
    logic out_blocked;
  } dp_status_t;

  // index of the last 16-bit chunk of the B operand for each step
  function automatic logic [CHUNK_IDX_W-1:0] op_last_chunk(mac_op_t op);
    logic [CHUNK_IDX_W-1:0] r;
    unique case (op)
      OP_N1X, OP_N1Y, OP_N2X, OP_N2Y, OP_DOTX, OP_DOTY: r = CHUNK_IDX_W'(1);
      OP_LHS, OP_RHS: r = CHUNK_IDX_W'(2);
      OP_K:           r = '0;
      default:        r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] clamp_dim(logic [CFG_W-1:0] v, int maxv);
    logic [CFG_W-1:0] r;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (int'(v) > maxv) begin
      r = CFG_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- hdl/corner_grid_collinearity_check.sv -----
// Top level of the chessboard corner grid collinearity check
//
// Corners enter in raster order, one beat per corner, tlast on the final corner of a set.
// Each corner is tested against the two before it in its row and the two above it in its
// column (|cos| >= 0.993, squared and compared in exact integers); on the tlast beat one
// result beat reports the count check, the line check and their AND. All products go
// through one shared 57x16 multiply-accumulate unit, one triple at a time, and a new
// corner is taken only once the last one is committed (including any wait for the
// result register to drain on a tlast beat). The line buffers hold no reset value.
`include "assert_macros.svh"

module corner_grid_collinearity_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cgcc_pkg::POINT_W-1:0]  s_tdata,   // corner_x, corner_y
  input  logic                          s_tlast,   // last_corner
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [cgcc_pkg::OUT_W-1:0]    m_tdata,   // count_ok, lines_ok, grid_good, zero pad
  input  logic                          cfg_we,
  input  logic [cgcc_pkg::REG_IDX_W-1:0] cfg_addr,
  input  logic [cgcc_pkg::CFG_W-1:0]    cfg_wdata
);
  import cgcc_pkg::*;

  logic [CFG_W-1:0] pattern_width, pattern_height;
  logic [CFG_W-1:0] width_eff, height_eff;
  ctl_cmd_t         cmd;
  dp_status_t       status;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_width  <= WIDTH_RESET;
      pattern_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PATTERN_WIDTH:  pattern_width  <= cfg_wdata;
        REG_PATTERN_HEIGHT: pattern_height <= cfg_wdata;
        default:            pattern_width  <= pattern_width;
      endcase
    end
  end

  assign width_eff  = clamp_dim(pattern_width, MAX_WIDTH);
  assign height_eff = clamp_dim(pattern_height, MAX_HEIGHT);

  cgcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cgcc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cmd        (cmd),
    .status     (status)
  );

  `ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready, "ready right after a beat")
  `ASSERT_IMPL(a_result_from_commit, $rose(m_tvalid), $past(cmd.commit), "result without commit")
  `ASSERT_IMPL(a_check_after_rhs, cmd.check, $past(cmd.mac_en) && ($past(cmd.op) == OP_RHS), "check before rhs done")

endmodule

// ----- hdl/cgcc_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module cgcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/cgcc_ctrl.sv -----
// Controller: sequences accept, triple tests on the shared multiplier, and commit
module cgcc_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  cgcc_pkg::dp_status_t   status,
  output cgcc_pkg::ctl_cmd_t     cmd
);
  import cgcc_pkg::*;

  ctl_state_t             state, state_next;
  mac_op_t                op, op_next;
  logic [CHUNK_IDX_W-1:0] chunk, chunk_next;
  logic                   doing_col, doing_col_next;

  function automatic mac_op_t next_op(mac_op_t o);
    mac_op_t r;
    unique case (o)
      OP_N1X:  r = OP_N1Y;
      OP_N1Y:  r = OP_N2X;
      OP_N2X:  r = OP_N2Y;
      OP_N2Y:  r = OP_DOTX;
      OP_DOTX: r = OP_DOTY;
      OP_DOTY: r = OP_LHS;
      OP_LHS:  r = OP_K;
      OP_K:    r = OP_RHS;
      OP_RHS:  r = OP_RHS;
      default: r = OP_N1X;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_N1X;
      chunk     <= '0;
      doing_col <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      chunk     <= chunk_next;
      doing_col <= doing_col_next;
    end
  end

  always_comb begin
    state_next     = state;
    op_next        = op;
    chunk_next     = chunk;
    doing_col_next = doing_col;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          priority if (status.row_test) begin
            state_next = S_LOAD_ROW;
          end else if (status.col_test) begin
            state_next = S_LOAD_COL;
          end else begin
            state_next = S_COMMIT;
          end
        end
      end
      S_LOAD_ROW: begin
        state_next     = S_MAC;
        op_next        = OP_N1X;
        chunk_next     = '0;
        doing_col_next = 1'b0;
      end
      S_LOAD_COL: begin
        state_next     = S_MAC;
        op_next        = OP_N1X;
        chunk_next     = '0;
        doing_col_next = 1'b1;
      end
      S_MAC: begin
        if (chunk == op_last_chunk(op)) begin
          chunk_next = '0;
          if (op == OP_RHS) begin
            state_next = S_CHECK;
          end else begin
            op_next = next_op(op);
          end
        end else begin
          chunk_next = chunk + 1'b1;
        end
      end
      S_CHECK: begin
        if (!doing_col && status.col_test) begin
          state_next = S_LOAD_COL;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (!status.out_blocked) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.op    = op;
    cmd.chunk = chunk;
    s_tready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
      end
      S_LOAD_ROW: cmd.load_row = 1'b1;
      S_LOAD_COL: cmd.load_col = 1'b1;
      S_MAC:      cmd.mac_en   = 1'b1;
      S_CHECK:    cmd.check    = 1'b1;
      S_COMMIT:   cmd.commit   = !status.out_blocked;
      default:    cmd.take     = 1'b0;
    endcase
  end

endmodule

// ----- hdl/cgcc_dp.sv -----
// Datapath: indices, line buffers, difference vectors, multiply-accumulate, result register
module cgcc_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [cgcc_pkg::CFG_W-1:0]  width_eff,
  input  logic [cgcc_pkg::CFG_W-1:0]  height_eff,
  input  logic [cgcc_pkg::POINT_W-1:0] s_tdata,
  input  logic                        s_tlast,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [cgcc_pkg::OUT_W-1:0]  m_tdata,
  input  cgcc_pkg::ctl_cmd_t          cmd,
  output cgcc_pkg::dp_status_t        status
);
  import cgcc_pkg::*;

  point_t                   cur, prev_p, prev_prev;
  logic                     last_q;
  logic [COL_W-1:0]         col, col_eff;
  logic [ROW_W-1:0]         row;
  logic [COUNT_W-1:0]       count;
  logic                     any_bad;
  logic                     active, col_wrap;
  logic [AREA_W-1:0]        area;
  logic                     count_ok, lines_ok;

  point_t                   above_rd, two_above_rd;
  logic                     ram_we;

  point_t                   p0, p1;
  logic [MAG_W-1:0]         dx1m, dy1m, dx2m, dy2m;
  logic                     sx1, sy1, sx2, sy2;

  logic [OPA_W-1:0]         opa;
  logic [OPB_W-1:0]         opb;
  logic                     neg, first, last_chunk;
  logic [CHUNK_W-1:0]       chunk_val;
  logic [PROD_W-1:0]        prod;
  logic signed [ACC_W-1:0]  term, acc_base, acc_next, acc;
  logic [NORM_W-1:0]        n1, n2, dot_abs;
  logic signed [DOT_W-1:0]  dot_q;
  logic [LHS_W-1:0]         lhs;
  logic [K_W-1:0]           k_q;
  logic                     pass;

  // sign and magnitude of b - a
  function automatic logic [MAG_W:0] sdiff(coord_t b, coord_t a);
    logic [COORD_W:0] d;
    d = {1'b0, b} - {1'b0, a};
    return d[COORD_W] ? {1'b1, MAG_W'(-d)} : {1'b0, d[MAG_W-1:0]};
  endfunction

  assign col_eff  = (int'(col) >= int'(width_eff)) ? '0 : col;
  assign active   = int'(row) < int'(height_eff);
  assign col_wrap = (int'(col_eff) + 1) >= int'(width_eff);
  assign area     = AREA_W'(width_eff) * AREA_W'(height_eff);
  assign count_ok = int'(count) == int'(area);
  assign lines_ok = !any_bad;

  assign status.row_test    = active && (int'(col_eff) >= 2);
  assign status.col_test    = active && (int'(row) >= 2);
  assign status.out_blocked = last_q && m_tvalid && !m_tready;

  assign ram_we = cmd.commit && active;

  cgcc_ram #(.WIDTH(POINT_W), .DEPTH(MAX_WIDTH)) u_row_above (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_eff),
    .wdata (cur),
    .raddr (col_eff),
    .rdata (above_rd)
  );

  cgcc_ram #(.WIDTH(POINT_W), .DEPTH(MAX_WIDTH)) u_row_two_above (
    .clk   (clk),
    .we    (ram_we),
    .waddr (col_eff),
    .wdata (above_rd),
    .raddr (col_eff),
    .rdata (two_above_rd)
  );

  assign p0 = cmd.load_col ? two_above_rd : prev_prev;
  assign p1 = cmd.load_col ? above_rd : prev_p;

  always_ff @(posedge clk) begin
    if (cmd.load_row || cmd.load_col) begin
      {sx1, dx1m} <= sdiff(p1.x, p0.x);
      {sy1, dy1m} <= sdiff(p1.y, p0.y);
      {sx2, dx2m} <= sdiff(cur.x, p1.x);
      {sy2, dy2m} <= sdiff(cur.y, p1.y);
    end
  end

  assign dot_abs = dot_q[DOT_W-1] ? NORM_W'(-dot_q) : NORM_W'(dot_q);

  always_comb begin
    opa   = '0;
    opb   = '0;
    neg   = 1'b0;
    first = 1'b0;
    unique case (cmd.op)
      OP_N1X: begin
        opa = OPA_W'(dx1m); opb = OPB_W'(dx1m); first = 1'b1;
      end
      OP_N1Y: begin
        opa = OPA_W'(dy1m); opb = OPB_W'(dy1m);
      end
      OP_N2X: begin
        opa = OPA_W'(dx2m); opb = OPB_W'(dx2m); first = 1'b1;
      end
      OP_N2Y: begin
        opa = OPA_W'(dy2m); opb = OPB_W'(dy2m);
      end
      OP_DOTX: begin
        opa = OPA_W'(dx1m); opb = OPB_W'(dx2m); neg = sx1 ^ sx2; first = 1'b1;
      end
      OP_DOTY: begin
        opa = OPA_W'(dy1m); opb = OPB_W'(dy2m); neg = sy1 ^ sy2;
      end
      OP_LHS: begin
        opa = OPA_W'(dot_abs); opb = OPB_W'(dot_abs); first = 1'b1;
      end
      OP_K: begin
        opa = OPA_W'(n1); opb = OPB_W'(COS_SQ_Q16); first = 1'b1;
      end
      OP_RHS: begin
        opa = OPA_W'(k_q); opb = OPB_W'(n2); first = 1'b1;
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  assign last_chunk = cmd.chunk == op_last_chunk(cmd.op);
  assign chunk_val  = opb[int'(cmd.chunk) * CHUNK_W +: CHUNK_W];
  assign prod       = PROD_W'(opa) * PROD_W'(chunk_val);
  assign term       = $signed(ACC_W'(prod) << (int'(cmd.chunk) * CHUNK_W));
  assign acc_base   = (first && cmd.chunk == '0) ? '0 : acc;
  assign acc_next   = neg ? acc_base - term : acc_base + term;

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      acc <= acc_next;
      if (last_chunk) begin
        unique case (cmd.op)
          OP_N1Y:  n1    <= acc_next[NORM_W-1:0];
          OP_N2Y:  n2    <= acc_next[NORM_W-1:0];
          OP_DOTY: dot_q <= acc_next[DOT_W-1:0];
          OP_LHS:  lhs   <= acc_next[LHS_W-1:0];
          OP_K:    k_q   <= acc_next[K_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // 65536*dot^2 >= K*n1*n2, zero-length vectors pass
  assign pass = (n1 == '0) || (n2 == '0) ||
                ({lhs, {COS_W{1'b0}}} >= CMP_W'(acc[CMP_W-1:0]));

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      cur    <= point_t'(s_tdata);
      last_q <= s_tlast;
    end
    if (cmd.commit && last_q) begin
      m_tdata <= OUT_W'({count_ok && lines_ok, lines_ok, count_ok});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      row       <= '0;
      count     <= '0;
      any_bad   <= 1'b0;
      prev_p    <= '0;
      prev_prev <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cmd.commit && last_q) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cmd.take && count != COUNT_MAX) begin
        count <= count + 1'b1;
      end else if (cmd.commit && last_q) begin
        count <= '0;
      end
      if (cmd.check && !pass) begin
        any_bad <= 1'b1;
      end else if (cmd.commit && last_q) begin
        any_bad <= 1'b0;
      end
      if (cmd.commit) begin
        if (last_q) begin
          col       <= '0;
          row       <= '0;
          prev_p    <= '0;
          prev_prev <= '0;
        end else if (active) begin
          prev_prev <= prev_p;
          prev_p    <= cur;
          if (col_wrap) begin
            col <= '0;
            row <= ROW_W'(row + 1'b1);
          end else begin
            col <= COL_W'(col_eff + 1'b1);
          end
        end
      end
    end
  end

endmodule

// ----- tb/tb_corner_grid_collinearity_check.sv -----
`timescale 1ns / 100ps
// Testbench for the corner grid collinearity check: grid sets streamed in, verdicts predicted
module tb_corner_grid_collinearity_check;

  typedef struct packed {
    bit grid_good;
    bit lines_ok;
    bit count_ok;
  } grid_verdict_t;

  typedef enum int {
    GRID_EXACT,
    GRID_JITTER,
    GRID_OUTLIER,
    GRID_RANDOM,
    GRID_DEGENERATE
  } grid_shape_t;

  localparam int unsigned COORD_MAX = 20'hFFFFF;

  class grid_verdict_tracker;
    bit [cgcc_pkg::CFG_W-1:0] width_reg;
    bit [cgcc_pkg::CFG_W-1:0] height_reg;
    cgcc_pkg::point_t row_above [cgcc_pkg::MAX_WIDTH];
    cgcc_pkg::point_t row_two_above [cgcc_pkg::MAX_WIDTH];
    cgcc_pkg::point_t prev_pt;
    cgcc_pkg::point_t prev_prev_pt;
    int unsigned col_idx;
    int unsigned row_idx;
    int unsigned corner_cnt;
    bit any_bad;
    grid_verdict_t verdict_q[$];
    int unsigned mismatches;

    function new();
      width_reg = cgcc_pkg::WIDTH_RESET;
      height_reg = cgcc_pkg::HEIGHT_RESET;
      foreach (row_above[i]) begin
        row_above[i] = '0;
        row_two_above[i] = '0;
      end
      mismatches = 0;
      clear_set();
    endfunction

    static function int unsigned eff_dim(bit [cgcc_pkg::CFG_W-1:0] v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function void clear_set();
      prev_pt = '0;
      prev_prev_pt = '0;
      col_idx = 0;
      row_idx = 0;
      corner_cnt = 0;
      any_bad = 1'b0;
    endfunction

    function void write_reg(bit [cgcc_pkg::REG_IDX_W-1:0] idx, bit [cgcc_pkg::CFG_W-1:0] val);
      if (idx == cgcc_pkg::REG_PATTERN_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    function int unsigned pending();
      return verdict_q.size();
    endfunction

    // |cos| >= 0.993 as 65536*dot^2 >= K*|a|^2*|b|^2, zero-length vectors pass
    function bit triple_passes(cgcc_pkg::point_t p0, cgcc_pkg::point_t p1,
                               cgcc_pkg::point_t p2);
      longint dx1, dy1, dx2, dy2, dot;
      longint unsigned mag;
      bit [127:0] n1, n2, ad, lhs, rhs;
      dx1 = longint'(p1.x) - longint'(p0.x);
      dy1 = longint'(p1.y) - longint'(p0.y);
      dx2 = longint'(p2.x) - longint'(p1.x);
      dy2 = longint'(p2.y) - longint'(p1.y);
      n1 = 128'(dx1 * dx1 + dy1 * dy1);
      n2 = 128'(dx2 * dx2 + dy2 * dy2);
      dot = dx1 * dx2 + dy1 * dy2;
      mag = (dot < 0) ? longint'(-dot) : longint'(dot);
      if (n1 == 0 || n2 == 0) return 1'b1;
      ad = {64'b0, mag} << 8;
      lhs = ad * ad;
      rhs = n1 * 128'(cgcc_pkg::COS_SQ_Q16) * n2;
      return lhs >= rhs;
    endfunction

    function void note_corner(cgcc_pkg::point_t cur, bit last);
      int unsigned w, h, c;
      grid_verdict_t v;
      w = eff_dim(width_reg, cgcc_pkg::MAX_WIDTH);
      h = eff_dim(height_reg, cgcc_pkg::MAX_HEIGHT);
      if (corner_cnt < cgcc_pkg::COUNT_MAX) corner_cnt++;
      if (row_idx < h) begin
        c = (col_idx >= w) ? 0 : col_idx;
        if (c >= 2 && !triple_passes(prev_prev_pt, prev_pt, cur)) any_bad = 1'b1;
        if (row_idx >= 2 && !triple_passes(row_two_above[c], row_above[c], cur))
          any_bad = 1'b1;
        row_two_above[c] = row_above[c];
        row_above[c] = cur;
        prev_prev_pt = prev_pt;
        prev_pt = cur;
        if (c + 1 >= w) begin
          col_idx = 0;
          row_idx++;
        end else begin
          col_idx = c + 1;
        end
      end
      if (last) begin
        v.count_ok = (corner_cnt == w * h);
        v.lines_ok = !any_bad;
        v.grid_good = v.count_ok && v.lines_ok;
        verdict_q = {verdict_q, v};
        clear_set();
      end
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("%0t ns mismatch: %s", $time, what);
    endtask

    task check_verdict(logic [cgcc_pkg::OUT_W-1:0] beat);
      grid_verdict_t want;
      if (verdict_q.size() == 0) begin
        report_mismatch($sformatf("verdict beat %b with none expected", beat));
        return;
      end
      want = verdict_q.pop_front();
      if (beat[0] !== want.count_ok)
        report_mismatch($sformatf("count_ok got %b want %b", beat[0], want.count_ok));
      if (beat[1] !== want.lines_ok)
        report_mismatch($sformatf("lines_ok got %b want %b", beat[1], want.lines_ok));
      if (beat[2] !== want.grid_good)
        report_mismatch($sformatf("grid_good got %b want %b", beat[2], want.grid_good));
    endtask
  endclass

  logic clk;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [cgcc_pkg::POINT_W-1:0] s_tdata = '0;   // corner_x, corner_y
  logic s_tlast = 1'b0;                         // last_corner
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [cgcc_pkg::OUT_W-1:0] m_tdata;          // count_ok, lines_ok, grid_good, pad
  logic cfg_we = 1'b0;
  logic [cgcc_pkg::REG_IDX_W-1:0] cfg_addr = '0;
  logic [cgcc_pkg::CFG_W-1:0] cfg_wdata = '0;

  grid_verdict_tracker tracker;
  bit sender_eager = 1'b0;
  int unsigned random_corners = 0;

  corner_grid_collinearity_check uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic bit [cgcc_pkg::CFG_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    if (r < 12) return 32;
    if (r < 16) return $urandom_range(33, 63);
    if (r < 22) return 1;
    if (r < 80) return $urandom_range(2, 6);
    return $urandom_range(7, 16);
  endfunction

  function automatic int rand_signed(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic int clip_coord(int v);
    if (v < 0) return 0;
    if (v > int'(COORD_MAX)) return COORD_MAX;
    return v;
  endfunction

  // entered and left at a falling edge; tvalid stays high unless a gap follows
  task automatic send_corner(int unsigned x, int unsigned y, bit last);
    int unsigned gap;
    cgcc_pkg::point_t pt;
    gap = sender_eager ? 0 : pick_gap();
    pt.x = cgcc_pkg::coord_t'(x);
    pt.y = cgcc_pkg::coord_t'(y);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pt;
    s_tlast <= last;
    do @(posedge clk); while (s_tready !== 1'b1);
    tracker.note_corner(pt, last);
    @(negedge clk);
  endtask

  task automatic settle_idle();
    s_tvalid <= 1'b0;
    while (tracker.pending() > 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_dims(bit [cgcc_pkg::CFG_W-1:0] w, bit [cgcc_pkg::CFG_W-1:0] h);
    settle_idle();
    cfg_we <= 1'b1;
    cfg_addr <= cgcc_pkg::REG_PATTERN_WIDTH;
    cfg_wdata <= w;
    tracker.write_reg(cgcc_pkg::REG_PATTERN_WIDTH, w);
    @(negedge clk);
    cfg_addr <= cgcc_pkg::REG_PATTERN_HEIGHT;
    cfg_wdata <= h;
    tracker.write_reg(cgcc_pkg::REG_PATTERN_HEIGHT, h);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // n corners laid on a lattice o + c*u + r*v, shaped per mode; corners past w*h are noise
  task automatic send_grid(int n, grid_shape_t shape);
    int w, h, lim_u, lim_v, ux, uy, vx, vy, ox, oy;
    int lo_x, hi_x, lo_y, hi_y, x, y, j, bad_at, r, c;
    w = grid_verdict_tracker::eff_dim(tracker.width_reg, cgcc_pkg::MAX_WIDTH);
    h = grid_verdict_tracker::eff_dim(tracker.height_reg, cgcc_pkg::MAX_HEIGHT);
    lim_u = (int'(COORD_MAX) / (2 * (w > 1 ? w - 1 : 1))) >> $urandom_range(0, 19);
    lim_v = (int'(COORD_MAX) / (2 * (h > 1 ? h - 1 : 1))) >> $urandom_range(0, 19);
    ux = rand_signed(lim_u);
    uy = rand_signed(lim_u);
    vx = rand_signed(lim_v);
    vy = rand_signed(lim_v);
    if (shape == GRID_DEGENERATE) begin
      if ($urandom_range(0, 1)) begin
        ux = 0;
        uy = 0;
      end else begin
        vx = 0;
        vy = 0;
      end
    end
    lo_x = ((w - 1) * ux < 0 ? (w - 1) * ux : 0) + ((h - 1) * vx < 0 ? (h - 1) * vx : 0);
    hi_x = ((w - 1) * ux > 0 ? (w - 1) * ux : 0) + ((h - 1) * vx > 0 ? (h - 1) * vx : 0);
    lo_y = ((w - 1) * uy < 0 ? (w - 1) * uy : 0) + ((h - 1) * vy < 0 ? (h - 1) * vy : 0);
    hi_y = ((w - 1) * uy > 0 ? (w - 1) * uy : 0) + ((h - 1) * vy > 0 ? (h - 1) * vy : 0);
    ox = $urandom_range(-lo_x, int'(COORD_MAX) - hi_x);
    oy = $urandom_range(-lo_y, int'(COORD_MAX) - hi_y);
    j = $urandom_range(1, 4);
    bad_at = $urandom_range(0, n - 1);
    for (int k = 0; k < n; k++) begin
      r = k / w;
      c = k % w;
      if (shape == GRID_RANDOM || k >= w * h || (shape == GRID_OUTLIER && k == bad_at)) begin
        x = $urandom_range(0, COORD_MAX);
        y = $urandom_range(0, COORD_MAX);
      end else begin
        x = ox + c * ux + r * vx;
        y = oy + c * uy + r * vy;
        if (shape == GRID_JITTER && $urandom_range(0, 2) == 0) begin
          x = clip_coord(x + int'($urandom_range(0, 2 * j)) - j);
          y = clip_coord(y + int'($urandom_range(0, 2 * j)) - j);
        end
      end
      send_corner(x, y, k == n - 1);
      random_corners++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) tracker.check_verdict(m_tdata);
  end

  initial begin
    int unsigned run, stall, r;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      r = $urandom_range(0, 99);
      run = (r < 10) ? $urandom_range(100, 300) : (r < 80) ? $urandom_range(1, 20) :
            $urandom_range(1, 3);
      r = $urandom_range(0, 99);
      stall = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) :
              (r < 98) ? $urandom_range(4, 12) : $urandom_range(20, 40);
      m_tready <= 1'b1;
      repeat (run) @(negedge clk);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  initial begin
    int unsigned span_pos [3];
    int unsigned we, area, n, pick;
    bit [cgcc_pkg::CFG_W-1:0] w6, h6;
    bit first_set;
    grid_shape_t shape;
    span_pos[0] = 0;
    span_pos[1] = 20'h80000;
    span_pos[2] = COORD_MAX;
    first_set = 1'b1;
    tracker = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // full-range 3x3 grid, all lines straight
    set_dims(3, 3);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_corner(span_pos[c], span_pos[r], r == 2 && c == 2);

    // single row: repeated point, then a surplus corner past the grid
    set_dims(3, 1);
    send_corner(5, 5, 0);
    send_corner(5, 5, 0);
    send_corner(900, 100, 0);
    send_corner(20'h12345, 20'h54321, 1);
    // doubling back on itself is still a line
    send_corner(0, 0, 0);
    send_corner(1000, 0, 0);
    send_corner(0, 0, 1);
    // 45-degree bend, not a line
    send_corner(0, 0, 0);
    send_corner(COORD_MAX, 0, 0);
    send_corner(0, COORD_MAX, 1);
    // set cut short
    send_corner(10, 10, 0);
    send_corner(20, 20, 1);

    // zero registers clamp to a 1x1 grid
    set_dims(0, 0);
    send_corner(COORD_MAX, COORD_MAX, 1);

    while (random_corners < 1250) begin
      if (first_set || $urandom_range(0, 9) < 3) begin
        w6 = pick_dim();
        we = grid_verdict_tracker::eff_dim(w6, cgcc_pkg::MAX_WIDTH);
        h6 = (we > 4) ? $urandom_range(0, 128 / we) : pick_dim();
        set_dims(w6, h6);
        first_set = 1'b0;
      end
      sender_eager = ($urandom_range(0, 3) == 0);
      area = grid_verdict_tracker::eff_dim(tracker.width_reg, cgcc_pkg::MAX_WIDTH) *
             grid_verdict_tracker::eff_dim(tracker.height_reg, cgcc_pkg::MAX_HEIGHT);
      n = area;
      shape = GRID_EXACT;
      pick = $urandom_range(0, 99);
      if (pick < 12) shape = GRID_JITTER;
      else if (pick < 22) shape = GRID_OUTLIER;
      else if (pick < 30) shape = GRID_RANDOM;
      else if (pick < 38) shape = GRID_DEGENERATE;
      else if (pick < 50) begin
        n = $urandom_range(1, area + 3);
        if (n == area) n = area + 1;
      end
      send_grid(n, shape);
    end

    settle_idle();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
